// File: rtl/des_pkg.sv
`timescale 1ns / 1ps

package des_pkg;

    localparam int NumRoundsDefault = 16;
    localparam int KeyDepth         = 16;
    localparam int KeyIndexWidth    = 4;
    localparam int SubkeyWidth      = 48;
    localparam int BlockWidth       = 64;
    localparam int HalfWidth        = 32;

    localparam logic CMD_WRITE_KEY = 1'b0;
    localparam logic CMD_CIPHER    = 1'b1;

    typedef logic [HalfWidth-1:0]   half_t;
    typedef logic [SubkeyWidth-1:0] subkey_t;
    typedef logic [BlockWidth-1:0]  block_t;

    localparam logic [6:0] PERM_IP [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [6:0] PERM_FP [64] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    localparam logic [5:0] PERM_E [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] PERM_P [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [3:0] SBOX [8][64] = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
          4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
          4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
          4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
          4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
          4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
          4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
        '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
          4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
          4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
          4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
          4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
          4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
          4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
          4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
        '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
          4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
          4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
          4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
          4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
          4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
          4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
        '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
          4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
          4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
          4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
          4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
          4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
          4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
          4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
        '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
          4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
          4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
          4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
          4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
          4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
          4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
          4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
        '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
          4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
          4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
          4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
          4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
          4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
          4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
          4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
        '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
          4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
          4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
          4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
          4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
          4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
          4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
          4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
        '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
          4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
          4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
          4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
          4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
          4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
          4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
          4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
    };

    // table entries count bit positions from the msb, starting at one
    function automatic block_t perm_ip(input block_t x);
        block_t r;
        r = '0;
        for (int k = 0; k < 64; k++)
        begin
            r[63-k] = x[6'(7'd64 - PERM_IP[k])];
        end
        return r;
    endfunction

    function automatic block_t perm_fp(input block_t x);
        block_t r;
        r = '0;
        for (int k = 0; k < 64; k++)
        begin
            r[63-k] = x[6'(7'd64 - PERM_FP[k])];
        end
        return r;
    endfunction

    function automatic subkey_t perm_e(input half_t x);
        subkey_t r;
        r = '0;
        for (int k = 0; k < 48; k++)
        begin
            r[47-k] = x[5'(6'd32 - PERM_E[k])];
        end
        return r;
    endfunction

    function automatic half_t perm_p(input half_t x);
        half_t r;
        r = '0;
        for (int k = 0; k < 32; k++)
        begin
            r[31-k] = x[5'(6'd32 - PERM_P[k])];
        end
        return r;
    endfunction

    // row from the outer bits, column from the inner four
    function automatic logic [3:0] sbox_lookup(input logic [2:0] box, input logic [5:0] six);
        logic [5:0] idx;
        idx = {six[5], six[0], six[4:1]};
        return SBOX[box][idx];
    endfunction

endpackage

// File: rtl/des_round.sv
`timescale 1ns / 1ps

module des_round
(
    input  des_pkg::half_t   l_in,
    input  des_pkg::half_t   r_in,
    input  des_pkg::subkey_t subkey,
    output des_pkg::half_t   l_out,
    output des_pkg::half_t   r_out
);

    des_pkg::subkey_t mixed;
    des_pkg::half_t   sbox_out;

    always_comb
    begin
        mixed = des_pkg::perm_e(r_in) ^ subkey;
        for (int i = 0; i < 8; i++)
        begin
            sbox_out[31-4*i -: 4] = des_pkg::sbox_lookup(3'(i), mixed[47-6*i -: 6]);
        end
    end

    assign l_out = r_in;
    assign r_out = l_in ^ des_pkg::perm_p(sbox_out);

endmodule

// File: rtl/des_block_cipher.sv
`timescale 1ns / 1ps

// DES data path with one Feistel round per pipeline stage: a block beat (cmd 1) passes
// through the NUM_ROUNDS round stages; one block can be taken every cycle, so the
// throughput is one block per clock while no waiting result is stalled.
// A stall against a waiting result freezes the whole pipeline. A subkey beat (cmd 0) is
// held off while any block is still before its last round, so every block is ciphered
// with the subkeys present when it was taken; once taken it writes its subkey and gives no
// result. All sixteen subkeys are zero after reset; no clearing pass is needed.

module des_block_cipher
#(
    parameter int NUM_ROUNDS = des_pkg::NumRoundsDefault
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic                                   cmd,
    input  logic [des_pkg::KeyIndexWidth-1:0]      key_index,
    input  des_pkg::subkey_t                       subkey_value,
    input  des_pkg::block_t                        block_in,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output des_pkg::block_t                        block_out
);

    des_pkg::subkey_t subkey_reg [des_pkg::KeyDepth];

    logic             vld_reg [NUM_ROUNDS];
    des_pkg::half_t   l_reg   [NUM_ROUNDS];
    des_pkg::half_t   r_reg   [NUM_ROUNDS];

    des_pkg::half_t   l_in    [NUM_ROUNDS];
    des_pkg::half_t   r_in    [NUM_ROUNDS];
    des_pkg::half_t   l_next  [NUM_ROUNDS];
    des_pkg::half_t   r_next  [NUM_ROUNDS];

    des_pkg::block_t  ip_block;
    logic             advance;
    logic             busy;
    logic             key_write;

    assign ip_block = des_pkg::perm_ip(block_in);
    assign advance  = !(vld_reg[NUM_ROUNDS-1] && result_stall);

    // blocks still before their last round
    always_comb
    begin
        busy = 1'b0;
        for (int k = 0; k < NUM_ROUNDS - 1; k++)
        begin
            busy = busy | vld_reg[k];
        end
    end

    assign item_stall = (cmd == des_pkg::CMD_CIPHER) ? !advance : busy;
    assign key_write  = item_valid && !item_stall && (cmd == des_pkg::CMD_WRITE_KEY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < des_pkg::KeyDepth; i++)
            begin
                subkey_reg[i] <= '0;
            end
        end
        else if (key_write)
        begin
            subkey_reg[key_index] <= subkey_value;
        end
    end

    always_comb
    begin
        l_in[0] = ip_block[63:32];
        r_in[0] = ip_block[31:0];
        for (int k = 1; k < NUM_ROUNDS; k++)
        begin
            l_in[k] = l_reg[k-1];
            r_in[k] = r_reg[k-1];
        end
    end

    for (genvar k = 0; k < NUM_ROUNDS; k++)
    begin : g_round
        des_round u_round
        (
            .l_in   (l_in[k]),
            .r_in   (r_in[k]),
            .subkey (subkey_reg[k]),
            .l_out  (l_next[k]),
            .r_out  (r_next[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_ROUNDS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= item_valid && (cmd == des_pkg::CMD_CIPHER);
            for (int k = 1; k < NUM_ROUNDS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < NUM_ROUNDS; k++)
            begin
                l_reg[k] <= l_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    // halves swapped before the final permutation
    assign result_valid = vld_reg[NUM_ROUNDS-1];
    assign block_out    = des_pkg::perm_fp({r_reg[NUM_ROUNDS-1], l_reg[NUM_ROUNDS-1]});

endmodule

// File: rtl/des_chk.sv
`timescale 1ns / 1ps

module des_chk
(
    input logic            clk,
    input logic            rst_n,
    input logic            item_valid,
    input logic            item_stall,
    input logic            cmd,
    input logic            result_valid,
    input logic            result_stall,
    input des_pkg::block_t block_out
);

    // a held result keeps its beat
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(block_out))
        else $error("stalled result beat changed or vanished");

    // a subkey beat never produces a result
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (cmd == des_pkg::CMD_WRITE_KEY)
            |=> !result_valid || $past(result_valid))
        else $error("result appeared after a subkey beat");

    // nothing leaves straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid right after reset");

endmodule

bind des_block_cipher des_chk u_des_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .block_out    (block_out)
);
